@@ src/br1_pkg.sv @@
// Shared types, constants and helper functions for the ByteRun1 row decoder.
// Depends on nothing; every other file in src imports it.
package br1_pkg;

    localparam int MAX_ROW_BYTES = 4096;
    localparam int CFG_W         = 13;
    localparam int ROW_W         = $clog2(MAX_ROW_BYTES + 1);
    localparam int CMP_W         = (ROW_W > 9) ? ROW_W : 9;
    localparam int QUEUE_DEPTH   = 4;
    localparam int QPTR_W        = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W        = $clog2(QUEUE_DEPTH + 1);

    localparam logic [7:0] HDR_NOP    = 8'h80;
    localparam logic       REG_ROW    = 1'b0;
    localparam logic       REG_MODE   = 1'b1;

    // Command handed from the front to the back: one byte plus how often it
    // appears, whether the last result ends the row, and the error marker.
    typedef struct packed {
        logic [7:0] data;
        logic [7:0] len;
        logic       done;
        logic       err;
    } br1_cmd_t;

    // Row length as the counter sees it: zero acts as one, and the length
    // saturates at the largest supported row.
    function automatic logic [ROW_W-1:0] eff_row(input logic [CFG_W-1:0] r);
        logic [ROW_W-1:0] v;
        if (r == '0)
        begin
            v = ROW_W'(1);
        end
        else if (32'(r) > MAX_ROW_BYTES)
        begin
            v = ROW_W'(MAX_ROW_BYTES);
        end
        else
        begin
            v = ROW_W'(r);
        end
        return v;
    endfunction

endpackage

@@ src/br1_front.sv @@
// Front end of the ByteRun1 row decoder: takes stream bytes, parses headers,
// keeps the row counter and queues one command per productive byte.
// Depends on br1_pkg.
module br1_front
    import br1_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    input  logic [7:0]       data_byte,
    input  logic             cfg_write,
    input  logic             cfg_index,
    input  logic [CFG_W-1:0] cfg_data,
    input  logic             q_full,
    output logic             q_push,
    output br1_cmd_t         q_cmd
);

    typedef enum logic [2:0] {
        PH_HEADER  = 3'b001,
        PH_LITERAL = 3'b010,
        PH_REPEAT  = 3'b100
    } phase_t;

    phase_t           phase_reg, phase_next;
    logic [7:0]       run_left_reg, run_left_next;
    logic [ROW_W-1:0] row_left_reg, row_left_next;
    logic             failed_reg, failed_next;
    logic [CFG_W-1:0] row_bytes_reg;
    logic             compressed_reg;

    logic             accept;
    logic             single_done;
    logic [ROW_W-1:0] single_left;
    logic [7:0]       count;
    logic [CMP_W-1:0] row_wide;

    assign in_stall = q_full && !failed_reg;
    assign accept   = in_valid && !in_stall && !failed_reg;
    assign row_wide = CMP_W'(row_left_reg);

    // One byte taken off the row counter.
    assign single_done = (row_left_reg <= ROW_W'(1));
    assign single_left = single_done ? eff_row(row_bytes_reg) : row_left_reg - ROW_W'(1);

    // Literal headers announce b+1 bytes, repeat headers 257-b.
    assign count = data_byte[7] ? (~data_byte + 8'd2) : (data_byte + 8'd1);

    always_comb
    begin
        phase_next    = phase_reg;
        run_left_next = run_left_reg;
        row_left_next = row_left_reg;
        failed_next   = failed_reg;
        q_push        = 1'b0;
        q_cmd         = '{data: data_byte, len: 8'd1, done: single_done, err: 1'b0};
        if (accept)
        begin
            if (!compressed_reg)
            begin
                q_push        = 1'b1;
                row_left_next = single_left;
            end
            else
            begin
                unique case (phase_reg)
                    PH_LITERAL:
                    begin
                        q_push        = 1'b1;
                        row_left_next = single_left;
                        run_left_next = run_left_reg - 8'd1;
                        if (run_left_reg <= 8'd1)
                        begin
                            phase_next    = PH_HEADER;
                            run_left_next = '0;
                        end
                    end
                    PH_REPEAT:
                    begin
                        q_push        = 1'b1;
                        q_cmd.len     = run_left_reg;
                        q_cmd.done    = (CMP_W'(run_left_reg) == row_wide);
                        if (row_wide > CMP_W'(run_left_reg))
                        begin
                            row_left_next = ROW_W'(row_wide - CMP_W'(run_left_reg));
                        end
                        else
                        begin
                            row_left_next = eff_row(row_bytes_reg);
                        end
                        run_left_next = '0;
                        phase_next    = PH_HEADER;
                    end
                    PH_HEADER:
                    begin
                        if (data_byte != HDR_NOP)
                        begin
                            if (CMP_W'(count) > row_wide)
                            begin
                                q_push      = 1'b1;
                                q_cmd       = '{data: 8'd0, len: 8'd0, done: 1'b0, err: 1'b1};
                                failed_next = 1'b1;
                                run_left_next = '0;
                            end
                            else
                            begin
                                run_left_next = count;
                                phase_next    = data_byte[7] ? PH_REPEAT : PH_LITERAL;
                            end
                        end
                    end
                    default:
                    begin
                        phase_next = PH_HEADER;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_HEADER;
            run_left_reg   <= '0;
            row_left_reg   <= ROW_W'(40);
            failed_reg     <= 1'b0;
            row_bytes_reg  <= CFG_W'(40);
            compressed_reg <= 1'b1;
        end
        else if (cfg_write)
        begin
            // A register write restarts the parser; a halt stays in force.
            phase_reg    <= PH_HEADER;
            run_left_reg <= '0;
            if (cfg_index == REG_ROW)
            begin
                row_bytes_reg <= cfg_data;
                row_left_reg  <= eff_row(cfg_data);
            end
            else
            begin
                compressed_reg <= cfg_data[0];
                row_left_reg   <= eff_row(row_bytes_reg);
            end
        end
        else
        begin
            phase_reg    <= phase_next;
            run_left_reg <= run_left_next;
            row_left_reg <= row_left_next;
            failed_reg   <= failed_next;
        end
    end

endmodule

@@ src/br1_cmd_fifo.sv @@
// Short command queue between the front and back ends of the decoder.
// Depends on br1_pkg.
module br1_cmd_fifo
    import br1_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push,
    input  br1_cmd_t push_cmd,
    output logic     full,
    input  logic     pop,
    output logic     head_valid,
    output br1_cmd_t head_cmd
);

    br1_cmd_t          store_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic              do_push, do_pop;

    assign full       = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_cmd   = store_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + QCNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            store_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            end
            count_reg <= count_next;
        end
    end

endmodule

@@ src/br1_back.sv @@
// Back end of the decoder: expands queued commands into results of up to two
// bytes and holds each result in an output register. Depends on br1_pkg.
module br1_back
    import br1_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       head_valid,
    input  br1_cmd_t   head_cmd,
    output logic       pop,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] first_byte,
    output logic [7:0] second_byte,
    output logic [1:0] byte_count,
    output logic       last_for_input,
    output logic       row_done,
    output logic       row_error
);

    logic       busy_reg, busy_next;
    logic [7:0] left_reg, left_next;
    logic       valid_reg, valid_next;
    logic [7:0] first_reg, second_reg;
    logic [1:0] count_reg;
    logic       last_reg, done_reg, err_reg;

    logic       load;
    logic [7:0] cur_left;
    logic       pair;
    logic [7:0] new_left;
    logic       piece_last;

    assign load       = head_valid && (!valid_reg || !out_stall);
    assign cur_left   = busy_reg ? left_reg : head_cmd.len;
    assign pair       = (cur_left >= 8'd2);
    assign new_left   = cur_left - (pair ? 8'd2 : 8'd1);
    assign piece_last = head_cmd.err || (new_left == '0);
    assign pop        = load && piece_last;

    always_comb
    begin
        busy_next  = busy_reg;
        left_next  = left_reg;
        valid_next = valid_reg && out_stall;
        if (load)
        begin
            valid_next = 1'b1;
            busy_next  = !piece_last;
            left_next  = new_left;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            last_reg <= piece_last;
            err_reg  <= head_cmd.err;
            if (head_cmd.err)
            begin
                first_reg  <= '0;
                second_reg <= '0;
                count_reg  <= 2'd0;
                done_reg   <= 1'b0;
            end
            else
            begin
                first_reg  <= head_cmd.data;
                second_reg <= pair ? head_cmd.data : 8'd0;
                count_reg  <= pair ? 2'd2 : 2'd1;
                done_reg   <= piece_last && head_cmd.done;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            left_reg  <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg  <= busy_next;
            left_reg  <= left_next;
            valid_reg <= valid_next;
        end
    end

    assign out_valid      = valid_reg;
    assign first_byte     = first_reg;
    assign second_byte    = second_reg;
    assign byte_count     = count_reg;
    assign last_for_input = last_reg;
    assign row_done       = done_reg;
    assign row_error      = err_reg;

    // An error result carries no bytes and closes its input.
    a_err_shape: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg && err_reg |-> last_reg && (count_reg == 2'd0) && !done_reg)
        else $error("error result malformed");

    // A row can only end on the final piece of a run.
    a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg && done_reg |-> last_reg)
        else $error("row end before the last piece of a run");

    // A run part-way through expansion keeps its command at the queue head.
    a_busy_head: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> head_valid && !head_cmd.err)
        else $error("expansion lost its command");

endmodule

@@ src/byterun1_row_decoder.sv @@
// Top level of the ByteRun1 (PackBits) row decoder: front end, command queue
// and back end. Depends on br1_pkg, br1_front, br1_cmd_fifo and br1_back.
//
// The decoder takes one stream byte per beat on the input channel and gives
// results of one or two decoded bytes per beat on the output channel. Header
// bytes produce nothing; each literal or raw byte produces one result, and a
// repeat of n bytes produces ceil(n/2) results, one per cycle unless stalled,
// the last of which may hold a single byte. The front end takes one byte per
// cycle and the back end issues one result per cycle, each unless stalled, so
// literal and raw data stream at one byte per cycle; the rate of a repeat is
// set by the back end's two-byte output register, and the four-entry command
// queue between the two ends lets the front keep taking bytes while a repeat
// drains, until the queue is full. A run longer than what is left of the row
// gives a single result with row_error set and no bytes, after which every
// input beat is accepted and dropped until reset. Configuration writes are
// to be made only while the block is idle; each write restarts the parser at
// a header and reloads the row counter, but leaves an error halt in place.
module byterun1_row_decoder
    import br1_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    input  logic [7:0]       data_byte,
    output logic             out_valid,
    input  logic             out_stall,
    output logic [7:0]       first_byte,
    output logic [7:0]       second_byte,
    output logic [1:0]       byte_count,
    output logic             last_for_input,
    output logic             row_done,
    output logic             row_error,
    input  logic             cfg_write,
    input  logic             cfg_index,
    input  logic [CFG_W-1:0] cfg_data
);

    // Commands travel from the parser to the expander through the queue.
    logic     q_full;
    logic     q_push;
    br1_cmd_t q_cmd;
    logic     q_pop;
    logic     q_head_valid;
    br1_cmd_t q_head;

    br1_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .data_byte (data_byte),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_cmd     (q_cmd)
    );

    br1_cmd_fifo u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_cmd   (q_cmd),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_head_valid),
        .head_cmd   (q_head)
    );

    br1_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .head_valid     (q_head_valid),
        .head_cmd       (q_head),
        .pop            (q_pop),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .first_byte     (first_byte),
        .second_byte    (second_byte),
        .byte_count     (byte_count),
        .last_for_input (last_for_input),
        .row_done       (row_done),
        .row_error      (row_error)
    );

endmodule
